// ===== hw/rtl/fdcd_pkg.sv =====
// ----------------------------------------------------------------------------
// FSK delay-line correlator demodulator package
// Fixed coefficients (2^-24 units) and configuration register indexes.
// ----------------------------------------------------------------------------
package fdcd_pkg;

  localparam int COEF_SHIFT = 24;

  // Rounding constant: one half in 2^-24 units.
  localparam logic [23:0] ROUND_HALF = 24'h80_0000;

  // Tracking gains. Keep and take of each average sum to exactly 2^24.
  localparam logic signed [15:0] RAIL_TAKE = 16'sd16777;
  localparam logic signed [18:0] AVG_TAKE  = 19'sd167772;

  // Low-pass pole coefficients and reciprocal gain.
  localparam logic signed [24:0] POLE_A  = -25'sd14790167;
  localparam logic signed [25:0] POLE_B  = 26'sd31442057;
  localparam longint             LP_GAIN = 31332;

  // Configuration register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_CARRIER_ON  = 2'd0;
  localparam logic [1:0] REG_CARRIER_OFF = 2'd1;
  localparam logic [1:0] REG_HYSTERESIS  = 2'd2;

  localparam logic [11:0] CARRIER_ON_RESET  = 12'd40;
  localparam logic [11:0] CARRIER_OFF_RESET = 12'd30;
  localparam logic [15:0] HYSTERESIS_RESET  = 16'd6554;

endpackage

// ===== hw/rtl/fsk_delay_correlator_demod.sv =====
// The sample is captured in the input register, then its result in the result
// register. One sample per cycle while the output is not stalled; the whole
// per-sample recurrence (tracking, carrier detect, correlator, low-pass) is combinational.
// Reset (synchronous, active high) empties both registers, restores the
// configuration defaults and returns all filter and detector state to its start.
// ----------------------------------------------------------------------------
// FSK delay-line correlator demodulator
// Mid-rail removal, carrier detect with hysteresis, sign correlator against a
// delayed copy, 2-pole low-pass and output slicer with hysteresis.
// ----------------------------------------------------------------------------
module fsk_delay_correlator_demod #(
  parameter int DELAY_TAPS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] adc_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        data_bit,
  output logic        carrier_present,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fdcd_pkg::*;

  localparam int RW  = FRAC_BITS + 14;  // rail, level and average, signed
  localparam int RPW = RW + 16;
  localparam int APW = RW + 19;
  localparam int YW  = FRAC_BITS + 4;   // filter output, signed
  localparam int PW  = YW + 27;
  localparam longint LP_STEP_L =
    ((LP_GAIN << FRAC_BITS) + (longint'(1) << (COEF_SHIFT - 1))) >>> COEF_SHIFT;
  localparam logic signed [YW-1:0] LP_STEP = YW'(LP_STEP_L);

  // Configuration registers
  logic [11:0] carrier_on_level;
  logic [11:0] carrier_off_level;
  logic [15:0] slice_level;

  // Pipeline registers
  logic        in_full;
  logic [11:0] sample_q;
  logic        advance;

  // Demodulator state
  logic signed [RW-1:0]     rail_level;
  logic signed [RW-1:0]     signal_average;
  logic                     carrier_flag;
  logic                     output_bit;
  logic [DELAY_TAPS-1:0]    sign_history;
  logic signed [YW-1:0]     lowpass_in0;
  logic signed [YW-1:0]     lowpass_in1;
  logic signed [YW-1:0]     lowpass_out0;
  logic signed [YW-1:0]     lowpass_out1;

  // Next values
  logic signed [RW-1:0]     rail_level_next;
  logic signed [RW-1:0]     signal_average_next;
  logic                     carrier_flag_next;
  logic                     output_bit_next;
  logic signed [YW-1:0]     y_next;
  logic                     corr;

  // Datapath intermediates
  logic signed [RW-1:0]     sample_fx;
  logic signed [RW-1:0]     wave;
  logic signed [RW-1:0]     mag;
  logic                     bit_now;
  logic signed [RPW-1:0]    rail_prod;
  logic signed [RPW-1:0]    rail_rnd;
  logic signed [RW-1:0]     avg_diff;
  logic signed [APW-1:0]    avg_prod;
  logic signed [APW-1:0]    avg_rnd;
  logic signed [RW-1:0]     on_level_fx;
  logic signed [RW-1:0]     off_level_fx;
  logic signed [YW-1:0]     x0;
  logic signed [YW-1:0]     x1;
  logic signed [YW-1:0]     x2;
  logic signed [YW+24:0]    pole_a_prod;
  logic signed [YW+25:0]    pole_b_prod;
  logic signed [PW-1:0]     pole_sum;
  logic [FRAC_BITS+15:0]    hyst_wide;
  logic signed [YW-1:0]     hyst;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_on_level  <= CARRIER_ON_RESET;
      carrier_off_level <= CARRIER_OFF_RESET;
      slice_level       <= HYSTERESIS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_CARRIER_ON:  carrier_on_level  <= pwdata[11:0];
        REG_CARRIER_OFF: carrier_off_level <= pwdata[11:0];
        REG_HYSTERESIS:  slice_level       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CARRIER_ON:  prdata = {20'd0, carrier_on_level};
      REG_CARRIER_OFF: prdata = {20'd0, carrier_off_level};
      REG_HYSTERESIS:  prdata = {16'd0, slice_level};
      default:         prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: the input register refills whenever its request moves on.
  // --------------------------------------------------------------------------
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      sample_q <= adc_sample;
    end
  end

  // --------------------------------------------------------------------------
  // Mid-rail tracking and carrier detect
  // --------------------------------------------------------------------------
  always_comb begin
    sample_fx = $signed(RW'({sample_q, {FRAC_BITS{1'b0}}}));
    wave      = sample_fx - rail_level;
    bit_now   = !wave[RW-1];
    mag       = wave[RW-1] ? -wave : wave;

    // Keep plus take is exactly 2^24, so each average moves by a rounded step.
    rail_prod       = wave * RAIL_TAKE;
    rail_rnd        = rail_prod + $signed(RPW'(ROUND_HALF));
    rail_level_next = rail_level + RW'(rail_rnd >>> COEF_SHIFT);

    avg_diff            = mag - signal_average;
    avg_prod            = avg_diff * AVG_TAKE;
    avg_rnd             = avg_prod + $signed(APW'(ROUND_HALF));
    signal_average_next = signal_average + RW'(avg_rnd >>> COEF_SHIFT);

    on_level_fx  = $signed(RW'({carrier_on_level, {FRAC_BITS{1'b0}}}));
    off_level_fx = $signed(RW'({carrier_off_level, {FRAC_BITS{1'b0}}}));

    carrier_flag_next = carrier_flag;
    if (!carrier_flag) begin
      if (signal_average_next > on_level_fx) begin
        carrier_flag_next = 1'b1;
      end
    end else begin
      if (signal_average_next < off_level_fx) begin
        carrier_flag_next = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Correlator, low-pass and output slicer
  // --------------------------------------------------------------------------
  always_comb begin
    corr = sign_history[0] ^ bit_now;

    x0 = lowpass_in0;
    x1 = lowpass_in1;
    x2 = corr ? LP_STEP : -LP_STEP;

    pole_a_prod = lowpass_out0 * POLE_A;
    pole_b_prod = lowpass_out1 * POLE_B;
    pole_sum    = PW'(pole_a_prod) + PW'(pole_b_prod) + $signed(PW'(ROUND_HALF));
    y_next      = x0 + (x1 <<< 1) + x2 + YW'(pole_sum >>> COEF_SHIFT);

    hyst_wide = {slice_level, {FRAC_BITS{1'b0}}} >> 16;
    hyst      = $signed(YW'(hyst_wide));

    output_bit_next = output_bit;
    if (!carrier_flag_next) begin
      output_bit_next = 1'b1;
    end else if (output_bit) begin
      if (y_next < -hyst) begin
        output_bit_next = 1'b0;
      end
    end else begin
      if (y_next > hyst) begin
        output_bit_next = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // State and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rail_level     <= $signed(RW'(longint'(2047) << FRAC_BITS));
      signal_average <= '0;
      carrier_flag   <= 1'b0;
      output_bit     <= 1'b1;
      sign_history   <= '1;
      lowpass_in0    <= '0;
      lowpass_in1    <= '0;
      lowpass_out0   <= '0;
      lowpass_out1   <= '0;
      out_valid      <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
      if (in_full) begin
        rail_level     <= rail_level_next;
        signal_average <= signal_average_next;
        carrier_flag   <= carrier_flag_next;
        output_bit     <= output_bit_next;
        sign_history   <= {bit_now, sign_history[DELAY_TAPS-1:1]};
        lowpass_in0    <= lowpass_in1;
        lowpass_in1    <= x2;
        lowpass_out0   <= lowpass_out1;
        lowpass_out1   <= y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_full) begin
      data_bit        <= output_bit_next;
      carrier_present <= carrier_flag_next;
    end
  end

endmodule

// ===== dv/fdcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FSK demodulator result checker
// Watches the sample, result and register channels. It keeps a bit-exact copy
// of the demodulator state, predicts each result and compares the fields.
// ----------------------------------------------------------------------------
module fdcd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [11:0] adc_sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        data_bit,
  input  logic        carrier_present,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          in_flight
);
  import fdcd_pkg::*;

  localparam int     TAPS      = 24;
  localparam int     QBITS     = 16;
  localparam int     SHIFT     = 24;
  localparam longint HALF_LSB  = longint'(1) << (SHIFT - 1);
  localparam longint MID_KEEP  = 16760439;
  localparam longint MID_TAKE  = 16777;
  localparam longint LVL_KEEP  = 16609444;
  localparam longint LVL_TAKE  = 167772;
  localparam longint FB_OLD    = -14790167;
  localparam longint FB_NEW    = 31442057;
  localparam longint LP_STEP   = ((longint'(31332) << QBITS) + HALF_LSB) >>> SHIFT;

  typedef struct packed {
    logic data_bit;
    logic carrier;
  } demod_result_t;

  demod_result_t demod_results_q[$];

  logic [11:0]     on_level;
  logic [11:0]     off_level;
  logic [15:0]     hysteresis;

  longint          mid_rail;
  longint          level_avg;
  logic            carrier;
  logic            mark;
  logic [TAPS-1:0] sign_hist;
  longint          lp_x [2];
  longint          lp_y [2];

  initial begin
    mismatches = 0;
    in_flight  = 0;
  end

  function automatic longint round_q(input longint v);
    return (v + HALF_LSB) >>> SHIFT;
  endfunction

  function automatic demod_result_t demod_predict(input logic [11:0] sample);
    longint        scaled;
    longint        wave;
    longint        mag;
    longint        thr;
    longint        x_new;
    longint        y_new;
    longint        hyst;
    logic          positive;
    logic          corr;
    demod_result_t res;
    scaled = sample;
    scaled = scaled << QBITS;
    // The difference is taken against the rail as it was before this sample.
    wave     = scaled - mid_rail;
    mag      = (wave >= 0) ? wave : -wave;
    positive = (wave >= 0);
    mid_rail  = round_q(mid_rail * MID_KEEP + scaled * MID_TAKE);
    level_avg = round_q(level_avg * LVL_KEEP + mag * LVL_TAKE);
    if (!carrier) begin
      thr = on_level;
      if (level_avg > (thr << QBITS)) carrier = 1'b1;
    end else begin
      thr = off_level;
      if (level_avg < (thr << QBITS)) carrier = 1'b0;
    end
    corr      = sign_hist[0] ^ positive;
    sign_hist = {positive, sign_hist[TAPS-1:1]};
    x_new = corr ? LP_STEP : -LP_STEP;
    y_new = lp_x[0] + 2 * lp_x[1] + x_new + round_q(lp_y[0] * FB_OLD + lp_y[1] * FB_NEW);
    lp_x[0] = lp_x[1];
    lp_x[1] = x_new;
    lp_y[0] = lp_y[1];
    lp_y[1] = y_new;
    hyst = hysteresis;
    if (!carrier) begin
      mark = 1'b1;
    end else if (mark) begin
      if (y_new < -hyst) mark = 1'b0;
    end else begin
      if (y_new > hyst) mark = 1'b1;
    end
    res.data_bit = mark;
    res.carrier  = carrier;
    return res;
  endfunction

  task automatic report(input string what);
    $display("%0d ns: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    demod_result_t want;
    logic [31:0]   reg_val;
    logic          known;
    if (rst) begin
      on_level   = CARRIER_ON_RESET;
      off_level  = CARRIER_OFF_RESET;
      hysteresis = HYSTERESIS_RESET;
      mid_rail   = longint'(2047) << QBITS;
      level_avg  = 0;
      carrier    = 1'b0;
      mark       = 1'b1;
      sign_hist  = '1;
      lp_x[0]    = 0;
      lp_x[1]    = 0;
      lp_y[0]    = 0;
      lp_y[1]    = 0;
      demod_results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (demod_results_q.size() == 0) begin
          report("result request with no sample outstanding");
        end else begin
          want = demod_results_q.pop_front();
          if (data_bit !== want.data_bit)
            report($sformatf("data_bit %b, predicted %b", data_bit, want.data_bit));
          if (carrier_present !== want.carrier)
            report($sformatf("carrier_present %b, predicted %b", carrier_present,
                             want.carrier));
        end
      end
      if (in_valid && !in_stall) demod_results_q.push_back(demod_predict(adc_sample));
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_CARRIER_ON:  on_level   = pwdata[11:0];
            REG_CARRIER_OFF: off_level  = pwdata[11:0];
            REG_HYSTERESIS:  hysteresis = pwdata[15:0];
            default: ;
          endcase
        end else begin
          known = 1'b1;
          case (paddr[3:2])
            REG_CARRIER_ON:  reg_val = {20'd0, on_level};
            REG_CARRIER_OFF: reg_val = {20'd0, off_level};
            REG_HYSTERESIS:  reg_val = {16'd0, hysteresis};
            default: begin
              reg_val = '0;
              known   = 1'b0;
            end
          endcase
          if (known && prdata !== reg_val)
            report($sformatf("register at 0x%h reads 0x%h, held 0x%h", paddr, prdata,
                             reg_val));
        end
      end
    end
    in_flight = demod_results_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FSK delay-line correlator demodulator testbench
// Drives a short directed burst, then phases of synthetic FSK tone bursts,
// quiet spells and noise under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import fdcd_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         SETTLE      = 6;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [11:0] adc_sample;
  logic        out_valid;
  logic        out_stall;
  logic        data_bit;
  logic        carrier_present;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int in_flight;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycles         = 0;

  int directed_samples [25] = '{2047, 2047, 2048, 2046, 4095, 0, 4095, 0, 4095, 0,
                                4095, 0, 1, 4094, 2047, 4095, 4095, 4095, 0, 0,
                                0, 2048, 2047, 1024, 3072};

  fsk_delay_correlator_demod dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .adc_sample      (adc_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_bit        (data_bit),
    .carrier_present (carrier_present),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  fdcd_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .adc_sample      (adc_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_bit        (data_bit),
    .carrier_present (carrier_present),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatches      (mismatches),
    .in_flight       (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [11:0] to_sample(input int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return v[11:0];
  endfunction

  task automatic push_sample(input logic [11:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid   = 1'b0;
      adc_sample = 12'($urandom);
      @(negedge clk);
    end
    in_valid   = 1'b1;
    adc_sample = value;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] index, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {index, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Let every outstanding request drain before touching the registers.
  task automatic settle();
    in_valid = 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_levels(input logic [31:0] on_val, input logic [31:0] off_val,
                            input logic [31:0] hyst_val);
    apb_access(1'b1, REG_CARRIER_ON, on_val);
    apb_access(1'b1, REG_CARRIER_OFF, off_val);
    apb_access(1'b1, REG_HYSTERESIS, hyst_val);
    apb_access(1'b1, REG_SPARE, $urandom);
    apb_access(1'b0, REG_CARRIER_ON, '0);
    apb_access(1'b0, REG_CARRIER_OFF, '0);
    apb_access(1'b0, REG_HYSTERESIS, '0);
  endtask

  // Mostly tone bursts, half at the two correlator extremes (period equal to the delay
  // or twice it), with random amplitude and offset, broken up by noise and quiet.
  task automatic fsk_stream(input int count);
    int done;
    int seg;
    int period;
    int amp;
    int centre;
    int noise;
    int kind;
    int ph;
    int v;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(9);
      seg  = $urandom_range(150, 40);
      case ($urandom_range(3))
        0:       period = 24;
        1:       period = 48;
        2:       period = 16;
        default: period = $urandom_range(64, 4);
      endcase
      amp    = $urandom_range(1) ? $urandom_range(120, 20) : $urandom_range(2047, 120);
      centre = 2047 + int'($urandom_range(400)) - 200;
      noise  = amp / 8;
      if (kind == 8) seg = $urandom_range(300, 100);
      for (ph = 0; ph < seg && done < count; ph++) begin
        if (kind <= 6)
          v = centre + (((ph % period) < period / 2) ? amp : -amp)
              + int'($urandom_range(2 * noise)) - noise;
        else if (kind == 7)
          v = $urandom_range(4095);
        else if (kind == 8)
          v = centre + int'($urandom_range(6)) - 3;
        else
          v = ((ph % period) < period / 2) ? 4095 : 0;
        push_sample(to_sample(v));
        done++;
      end
    end
  endtask

  initial begin
    logic [31:0] on_val;
    rst        = 1'b1;
    in_valid   = 1'b0;
    adc_sample = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (directed_samples[i]) push_sample(to_sample(directed_samples[i]));

    for (int phase = 0; phase < 7; phase++) begin
      settle();
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          set_levels(32'd40, 32'd30, 32'd6554);
          fsk_stream(250);
        end
        1: begin
          send_idle_pct  = 64;
          recv_stall_pct = 0;
          set_levels(32'd0, 32'd0, 32'd0);
          fsk_stream(200);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 64;
          set_levels(32'd4095, 32'd4095, 32'd65535);
          fsk_stream(150);
        end
        3: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
          set_levels(32'd100, 32'd20, 32'd3000);
          fsk_stream(250);
        end
        4: begin
          // Upper bits beyond each register's width must be dropped.
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          set_levels(32'hABCD_E064, 32'h1234_5014, 32'hFFFF_2000);
          fsk_stream(250);
        end
        5: begin
          send_idle_pct  = 64;
          recv_stall_pct = 64;
          set_levels(32'd60, 32'd59, 32'd65535);
          fsk_stream(200);
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
          on_val = $urandom_range(150);
          set_levels(($urandom & 32'hFFFF_F000) | on_val,
                     ($urandom & 32'hFFFF_F000) | $urandom_range(on_val),
                     ($urandom & 32'hFFFF_0000) | $urandom_range(20000));
          fsk_stream(250);
        end
      endcase
    end

    settle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== fsk_delay_correlator_demod.f =====
hw/rtl/fdcd_pkg.sv
hw/rtl/fsk_delay_correlator_demod.sv
dv/fdcd_checker.sv
dv/testbench.sv
